// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk while rst_n is high.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that trig at one edge implies prop at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, trig, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error("assertion failed");

`endif

// ===== sv/rcfd_pkg.sv =====
// Package: types and constants of the remote-control channel frame decoder.
package rcfd_pkg;

  localparam int unsigned NUM_CHANNELS = 9;
  localparam int unsigned MODE_BYTES   = 4;
  localparam int unsigned MODE_W       = 3;
  localparam int unsigned MODE_WORD_W  = NUM_CHANNELS * MODE_W;
  localparam int unsigned CH_W         = 4;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned OUT_DATA_W   = 16;

  localparam logic [MODE_W-1:0] MODE_SERVO        = 3'b001;
  localparam logic [MODE_W-1:0] MODE_PWM          = 3'b010;
  localparam logic [MODE_W-1:0] MODE_DIGITAL_HIGH = 3'b111;

  localparam logic [CH_W-1:0]  LAST_CH      = CH_W'(NUM_CHANNELS - 1);
  localparam logic [POS_W-1:0] LAST_MODE_POS = POS_W'(MODE_BYTES - 1);
  localparam logic [POS_W-1:0] POS_MAX      = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_EMIT
  } state_t;

  // True for modes that take a value byte from the frame.
  function automatic logic needs_value(input logic [MODE_W-1:0] m);
    return (m == MODE_SERVO) || (m == MODE_PWM);
  endfunction

endpackage

// ===== sv/rc_channel_frame_decoder.sv =====
// Top level: remote-control channel frame decoder with a shared mode-scan unit.
// Throughput: one byte per cycle while ready, except the fourth byte of a frame, after
//   which a scan counts the servo and PWM channels (input not ready).
// Output: the last byte starts 9 results, one per cycle while out_tready is high; a
//   frame that ends within its four mode bytes first runs the scan.
// The single mode scanner serves both the count and the result burst.
// Reset: rst_n low (synchronous) returns to idle with an empty frame and no result.
module rc_channel_frame_decoder
  import rcfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] rx_byte
  input  logic                  in_tlast,   // last_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [3:0] channel_index, [6:4] channel_mode,
                                            // [14:7] channel_value, [15] zero
  output logic                  out_tuser,  // frame_short
  output logic                  out_tlast   // last_channel
);

  // Sequencer state.
  state_t state_r, state_nxt;

  // Frame state.
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [MODE_WORD_W-1:0] mode_word_r, mode_word_nxt;
  logic [CH_W-1:0]        slot_cnt_r, slot_cnt_nxt;
  logic [CH_W-1:0]        need_r, need_nxt;
  logic [BYTE_W-1:0]      vals_r [NUM_CHANNELS];

  // Shared scan unit: a shift copy of the mode word, one channel per step.
  logic [MODE_WORD_W-1:0] scan_r, scan_nxt;
  logic [CH_W-1:0]        step_r, step_nxt;
  logic [CH_W-1:0]        rd_slot_r, rd_slot_nxt;
  logic                   emit_after_r, emit_after_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                   in_xfer;
  logic                   store_val;
  logic                   scan_go;
  logic                   out_load;
  logic                   last_step;
  logic [MODE_W-1:0]      scan_mode;
  logic                   scan_needs;
  logic [BYTE_W-1:0]      emit_val;
  logic [MODE_WORD_W-1:0] byte_bits;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  assign scan_mode  = scan_r[MODE_WORD_W-1 -: MODE_W];
  assign scan_needs = needs_value(scan_mode);
  assign last_step  = (step_r == LAST_CH);
  // Refill the output register when it is empty or being taken.
  assign out_load   = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  // Scan after the last mode byte, or at a frame end that came before it.
  assign scan_go    = (pos_r == LAST_MODE_POS) || (in_tlast && (pos_r < LAST_MODE_POS));
  assign store_val  = (pos_r > LAST_MODE_POS) && (slot_cnt_r < need_r);

  // Place an incoming mode byte: channel 0 lands in the top bits.
  always_comb begin
    case (pos_r)
      4'd0:    byte_bits = MODE_WORD_W'({in_tdata, 19'd0});
      4'd1:    byte_bits = MODE_WORD_W'({in_tdata, 11'd0});
      4'd2:    byte_bits = MODE_WORD_W'({in_tdata, 3'd0});
      4'd3:    byte_bits = MODE_WORD_W'(in_tdata[7:5]);
      default: byte_bits = '0;
    endcase
  end

  // Value of the channel under the scanner during the result burst.
  always_comb begin
    emit_val = '0;
    if (scan_needs) begin
      if (rd_slot_r < slot_cnt_r) begin
        emit_val = vals_r[rd_slot_r];
      end
    end else if (scan_mode == MODE_DIGITAL_HIGH) begin
      emit_val = BYTE_W'(1);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (scan_go) begin
            state_nxt = ST_COUNT;
          end else if (in_tlast) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_COUNT: begin
        if (last_step) begin
          state_nxt = emit_after_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_load && last_step) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    pos_nxt        = pos_r;
    mode_word_nxt  = mode_word_r;
    slot_cnt_nxt   = slot_cnt_r;
    need_nxt       = need_r;
    scan_nxt       = scan_r;
    step_nxt       = step_r;
    rd_slot_nxt    = rd_slot_r;
    emit_after_nxt = emit_after_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          mode_word_nxt = mode_word_r | byte_bits;
          if (pos_r != POS_MAX) begin
            pos_nxt = pos_r + POS_W'(1);
          end
          if (store_val) begin
            slot_cnt_nxt = slot_cnt_r + CH_W'(1);
          end
          // Load the scanner with the mode word as it stands after this byte.
          scan_nxt       = mode_word_r | byte_bits;
          step_nxt       = '0;
          rd_slot_nxt    = '0;
          emit_after_nxt = in_tlast;
          if (scan_go) begin
            need_nxt = '0;
          end
        end
      end
      ST_COUNT: begin
        if (scan_needs) begin
          need_nxt = need_r + CH_W'(1);
        end
        step_nxt = step_r + CH_W'(1);
        scan_nxt = scan_r << MODE_W;
        if (last_step) begin
          // Rewind for the result burst.
          scan_nxt = mode_word_r;
          step_nxt = '0;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, emit_val, scan_mode, step_r};
          out_user_nxt  = (need_r > slot_cnt_r);
          out_last_nxt  = last_step;
          if (scan_needs) begin
            rd_slot_nxt = rd_slot_r + CH_W'(1);
          end
          step_nxt = step_r + CH_W'(1);
          scan_nxt = scan_r << MODE_W;
          if (last_step) begin
            // Drop the frame and start over.
            pos_nxt       = '0;
            mode_word_nxt = '0;
            slot_cnt_nxt  = '0;
            need_nxt      = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= '0;
      mode_word_r  <= '0;
      slot_cnt_r   <= '0;
      need_r       <= '0;
      step_r       <= '0;
      rd_slot_r    <= '0;
      emit_after_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      mode_word_r  <= mode_word_nxt;
      slot_cnt_r   <= slot_cnt_nxt;
      need_r       <= need_nxt;
      step_r       <= step_nxt;
      rd_slot_r    <= rd_slot_nxt;
      emit_after_r <= emit_after_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
    if (in_xfer && store_val) begin
      vals_r[slot_cnt_r] <= in_tdata;
    end
  end

endmodule

// ===== sv/rcfd_checker.sv =====
// Checker: port-level assertions for the frame decoder, bound to the top level.
`include "assert_macros.svh"

module rcfd_checker
  import rcfd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser,
  input logic                  out_tlast
);

  logic [CH_W-1:0]   chk_index;
  logic [MODE_W-1:0] chk_mode;
  logic [BYTE_W-1:0] chk_value;

  assign chk_index = out_tdata[3:0];
  assign chk_mode  = out_tdata[6:4];
  assign chk_value = out_tdata[14:7];

  // A stalled result holds.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // The last result of a frame is channel eight, and only it.
  `ASSERT_CLK(a_last_is_eight, clk, rst_n,
    !out_tvalid || (out_tlast == (chk_index == LAST_CH)))

  // Modes without a value byte or digital high report zero.
  `ASSERT_CLK(a_zero_value, clk, rst_n,
    !out_tvalid || chk_mode == MODE_SERVO || chk_mode == MODE_PWM ||
    chk_mode == MODE_DIGITAL_HIGH || chk_value == '0)

  // Digital high reports one.
  `ASSERT_CLK(a_high_value, clk, rst_n,
    !out_tvalid || chk_mode != MODE_DIGITAL_HIGH || chk_value == BYTE_W'(1))

  // No byte is taken while a burst still has channels to send.
  `ASSERT_CLK(a_no_input_in_burst, clk, rst_n,
    !(out_tvalid && !out_tlast && in_tvalid && in_tready))

endmodule

bind rc_channel_frame_decoder rcfd_checker u_rcfd_checker (.*);

// ===== tb/rc_channel_frame_decoder_tb.sv =====
// Self-checking testbench for the remote-control channel frame decoder.
module rc_channel_frame_decoder_tb
  import rcfd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Mode codes the package leaves unnamed.
  localparam logic [MODE_W-1:0] MODE_OFF         = 3'b000;
  localparam logic [MODE_W-1:0] MODE_RSVD3       = 3'b011;
  localparam logic [MODE_W-1:0] MODE_RSVD4       = 3'b100;
  localparam logic [MODE_W-1:0] MODE_RSVD5       = 3'b101;
  localparam logic [MODE_W-1:0] MODE_DIGITAL_LOW = 3'b110;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  // Receiver stall styles, switched in phases of random length.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_style_t;

  typedef struct {
    logic [CH_W-1:0]   index;
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] value;
    logic              frame_short;
    logic              last_channel;
  } chan_result_t;

  // Decodes accepted bytes into expected channel results and checks the DUT output.
  class frame_decode_checker;
    logic [POS_W-1:0]       byte_count;
    logic [MODE_WORD_W-1:0] modes_packed;
    int unsigned            stored_values;
    logic [BYTE_W-1:0]      value_bytes[NUM_CHANNELS];
    chan_result_t           pending_channels[$];
    int unsigned            errors;
    int unsigned            frames;
    int unsigned            short_frames;
    int unsigned            checked;

    function new();
      errors = 0;
      frames = 0;
      short_frames = 0;
      checked = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_count = '0;
      modes_packed = '0;
      stored_values = 0;
      foreach (value_bytes[i]) value_bytes[i] = '0;
    endfunction

    function logic [MODE_W-1:0] mode_at(int unsigned ch);
      return modes_packed[MODE_WORD_W-1-MODE_W*ch -: MODE_W];
    endfunction

    function bit takes_value(logic [MODE_W-1:0] m);
      return (m == MODE_SERVO) || (m == MODE_PWM);
    endfunction

    function int unsigned values_wanted();
      int unsigned n;
      n = 0;
      for (int unsigned ch = 0; ch < NUM_CHANNELS; ch++)
        if (takes_value(mode_at(ch))) n++;
      return n;
    endfunction

    // Advance the frame by one accepted byte; at the last byte queue nine results.
    function void take_byte(logic [BYTE_W-1:0] b, logic is_last);
      chan_result_t r;
      int unsigned  wanted;
      int unsigned  slot;
      bit           is_short;
      if (byte_count < MODE_BYTES) begin
        case (byte_count)
          0: modes_packed = modes_packed | (MODE_WORD_W'(b) << 19);
          1: modes_packed = modes_packed | (MODE_WORD_W'(b) << 11);
          2: modes_packed = modes_packed | (MODE_WORD_W'(b) << 3);
          default: modes_packed = modes_packed | MODE_WORD_W'(b >> 5);
        endcase
      end else begin
        wanted = values_wanted();
        if (stored_values < wanted && stored_values < NUM_CHANNELS) begin
          value_bytes[stored_values] = b;
          stored_values++;
        end
      end
      if (byte_count != POS_MAX) byte_count++;
      if (!is_last) return;

      wanted = values_wanted();
      is_short = wanted > stored_values;
      slot = 0;
      for (int unsigned ch = 0; ch < NUM_CHANNELS; ch++) begin
        r.index = CH_W'(ch);
        r.mode = mode_at(ch);
        r.value = '0;
        if (takes_value(r.mode)) begin
          if (slot < stored_values) r.value = value_bytes[slot];
          slot++;
        end else if (r.mode == MODE_DIGITAL_HIGH) begin
          r.value = 8'd1;
        end
        r.frame_short = is_short;
        r.last_channel = (ch == NUM_CHANNELS - 1);
        pending_channels.push_back(r);
      end
      frames++;
      if (is_short) short_frames++;
      clear_frame();
    endfunction

    // Compare one accepted result transfer with the oldest expected channel.
    function void check_channel(logic [OUT_DATA_W-1:0] data, logic user, logic lst);
      chan_result_t exp_r;
      if (pending_channels.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual data=%h short=%b last=%b",
                 $time, data, user, lst);
        errors++;
        return;
      end
      exp_r = pending_channels.pop_front();
      checked++;
      if (data[3:0] != exp_r.index) begin
        $display("%0t: channel_index mismatch: expected %0d, actual %0d",
                 $time, exp_r.index, data[3:0]);
        errors++;
      end
      if (data[6:4] != exp_r.mode) begin
        $display("%0t: channel_mode mismatch (ch %0d): expected %0d, actual %0d",
                 $time, exp_r.index, exp_r.mode, data[6:4]);
        errors++;
      end
      if (data[14:7] != exp_r.value) begin
        $display("%0t: channel_value mismatch (ch %0d): expected %h, actual %h",
                 $time, exp_r.index, exp_r.value, data[14:7]);
        errors++;
      end
      if (data[15] !== 1'b0) begin
        $display("%0t: tdata pad bit mismatch: expected 0, actual %b", $time, data[15]);
        errors++;
      end
      if (user != exp_r.frame_short) begin
        $display("%0t: frame_short mismatch (ch %0d): expected %b, actual %b",
                 $time, exp_r.index, exp_r.frame_short, user);
        errors++;
      end
      if (lst != exp_r.last_channel) begin
        $display("%0t: last_channel mismatch (ch %0d): expected %b, actual %b",
                 $time, exp_r.index, exp_r.last_channel, lst);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  frame_decode_checker decode_chk = new();

  // Sender burst bookkeeping and receiver hold-off requests.
  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned rx_phase_left = 0;
  rx_style_t   rx_style = RX_OPEN;

  rc_channel_frame_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] rx_byte
    .in_tlast   (in_tlast),   // last_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [3:0] index, [6:4] mode, [14:7] value, [15] zero
    .out_tuser  (out_tuser),  // frame_short
    .out_tlast  (out_tlast)   // last_channel
  );

  always #10 clk = ~clk;

  // Receiver: check every result transfer, then pick tready for the next edge.
  // A long hold-off is served on request; otherwise stall in phases of varying style.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      decode_chk.check_channel(out_tdata, out_tuser, out_tlast);
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_style = rx_style_t'($urandom_range(0, 3));
        rx_phase_left = $urandom_range(10, 60);
      end
      rx_phase_left--;
      case (rx_style)
        RX_OPEN:   out_tready <= 1'b1;
        RX_LIGHT:  out_tready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY:  out_tready <= ($urandom_range(0, 2) == 0);
        default:   out_tready <= ~out_tready;
      endcase
    end
  end

  // Offer one byte and hold it until the transfer happens. Gaps fall between
  // bursts of random length; a zero gap keeps tvalid high across items.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_chk.take_byte(b, is_last);
    bytes_sent++;
  endtask

  // Send a whole frame; the final byte carries tlast. Drop tvalid afterward
  // only if the next call opens with a gap.
  task automatic send_frame(input logic [BYTE_W-1:0] frame_q[$]);
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Hold the sender until every expected result has been transferred.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (decode_chk.pending_channels.size() != 0) @(posedge clk);
  endtask

  // Pack nine modes high bit first into four bytes; the spare low bits of the
  // fourth byte are random.
  function automatic void add_mode_bytes(input logic [MODE_W-1:0] m[NUM_CHANNELS],
                                         ref logic [BYTE_W-1:0] q[$]);
    logic [MODE_WORD_W-1:0] w;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) w[MODE_WORD_W-1-MODE_W*ch -: MODE_W] = m[ch];
    q.push_back(w[26:19]);
    q.push_back(w[18:11]);
    q.push_back(w[10:3]);
    q.push_back({w[2:0], 5'($urandom_range(0, 31))});
  endfunction

  function automatic logic [BYTE_W-1:0] value_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [MODE_W-1:0] modes[NUM_CHANNELS];
    logic [BYTE_W-1:0] frame_q[$];
    int unsigned       wanted;
    int unsigned       kind;
    int unsigned       n;
    int unsigned       frame_no;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Frame ends on its first byte: unsent mode bits read as mode 0.
    frame_q = '{8'hFF};
    send_frame(frame_q);

    // Every mode at least once (PWM twice), values 00, FF and 80, one extra byte to drop.
    modes = '{MODE_SERVO, MODE_PWM, MODE_OFF, MODE_RSVD3, MODE_RSVD4, MODE_RSVD5,
              MODE_DIGITAL_LOW, MODE_DIGITAL_HIGH, MODE_PWM};
    frame_q = {};
    add_mode_bytes(modes, frame_q);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h80);
    frame_q.push_back(8'h55);
    send_frame(frame_q);

    // All channels digital high, mode bytes only.
    frame_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame(frame_q);

    // All servo with a single value byte: short frame.
    foreach (modes[i]) modes[i] = MODE_SERVO;
    frame_q = {};
    add_mode_bytes(modes, frame_q);
    frame_q.push_back(8'hFF);
    send_frame(frame_q);

    // Random frames: mostly well formed, the rest short, padded or plain noise.
    frame_no = 0;
    while (bytes_sent < 230) begin
      frame_no++;
      if (frame_no == 5) wait_drained();
      // Stall the receiver long enough that the decoder backs up into its input.
      if (frame_no == 3 || frame_no == 8) hold_requests++;
      frame_q = {};
      kind = $urandom_range(0, 99);
      if (kind >= 90) begin
        n = $urandom_range(1, 20);
        repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        wanted = 0;
        foreach (modes[i]) begin
          if ($urandom_range(0, 99) < 60)
            modes[i] = $urandom_range(0, 1) ? MODE_SERVO : MODE_PWM;
          else
            modes[i] = MODE_W'($urandom_range(0, 7));
          if (modes[i] == MODE_SERVO || modes[i] == MODE_PWM) wanted++;
        end
        add_mode_bytes(modes, frame_q);
        if (kind < 60) begin
          repeat (wanted) frame_q.push_back(value_byte());
        end else if (kind < 75) begin
          // Cut the frame anywhere, possibly inside the mode bytes.
          n = $urandom_range(1, MODE_BYTES + wanted);
          if (n < MODE_BYTES + wanted) begin
            while (frame_q.size() > n) void'(frame_q.pop_back());
            repeat (n - frame_q.size()) frame_q.push_back(value_byte());
          end else begin
            repeat (wanted) frame_q.push_back(value_byte());
          end
        end else begin
          repeat (wanted + $urandom_range(1, 10)) frame_q.push_back(value_byte());
        end
      end
      send_frame(frame_q);
    end

    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    while (decode_chk.pending_channels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d frames in %0d bytes (%0d short), checked %0d channel results",
             decode_chk.frames, bytes_sent, decode_chk.short_frames, decode_chk.checked);
    $display("Included two long receiver hold-offs and a full drain mid-run");
    if (decode_chk.errors == 0 && decode_chk.pending_channels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/rcfd_pkg.sv
sv/rc_channel_frame_decoder.sv
sv/rcfd_checker.sv
tb/rc_channel_frame_decoder_tb.sv
